/* rtl/vtei_pkg.sv */
// ----------------------------------------------------------------------------
// Vertex table package
// Shared widths, payload structs and the command and status groups that
// pass between the vertex table controller and its datapath.
// ----------------------------------------------------------------------------
package vtei_pkg;

   // Table geometry and field widths.
   localparam int TABLE_DEPTH = 4096;
   localparam int SLOT_W      = $clog2(TABLE_DEPTH);
   localparam int SIZE_W      = SLOT_W + 1;
   localparam int NAME_W      = 32;
   localparam int DEG_W       = 16;

   localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(TABLE_DEPTH);
   localparam logic [DEG_W-1:0]  DEG_MAX  = '1;

   // The remainder unit retires two dividend bits per cycle.
   localparam int DIV_STEPS = NAME_W / 2;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // One edge as it arrives on the request channel.
   typedef struct packed {
      logic [NAME_W-1:0] vertex_a;
      logic [NAME_W-1:0] vertex_b;
   } req_type;

   // One result as it leaves on the response channel.
   typedef struct packed {
      logic [SLOT_W-1:0] slot_a;
      logic [SLOT_W-1:0] slot_b;
      logic [DEG_W-1:0]  degree_a;
      logic [DEG_W-1:0]  degree_b;
      logic [DEG_W-1:0]  max_degree;
      logic              table_full;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear_wr;    // clear one table entry and advance the sweep
      logic load_req;    // capture the edge and start both remainders
      logic start_a;     // begin probing at the home slot of vertex_a
      logic start_b;     // begin probing at the home slot of vertex_b
      logic eval;        // evaluate the table word read for this probe
      logic sel_b;       // the probe in progress belongs to vertex_b
      logic probe_next;  // step to the next slot with wraparound
      logic bump;        // compute the new degrees and the peak
      logic write_a;     // write back the entry of vertex_a
      logic write_b;     // write back the entry of vertex_b
      logic undo;        // release a slot taken for vertex_a
      logic out_load;    // load the response register
      logic out_fail;    // the response reports a full table
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_last;  // the clearing sweep is at its last entry
      logic div_done;    // both home slots are known
      logic hit;         // the slot read holds the name or is free
      logic probe_last;  // this probe is the last the table size allows
      logic out_free;    // the response register can take a new result
   } stat_type;

endpackage

/* rtl/vtei_div.sv */
// ----------------------------------------------------------------------------
// Vertex table remainder unit
// Computes a 32-bit name modulo the table size by restoring division,
// two dividend bits per cycle.
// ----------------------------------------------------------------------------
module vtei_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [vtei_pkg::NAME_W-1:0] dividend,
   input  logic [vtei_pkg::SIZE_W-1:0] divisor,
   output logic                        busy,
   output logic [vtei_pkg::SLOT_W-1:0] remainder
);
   import vtei_pkg::*;

   logic                 busy_ff, busy_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [NAME_W-1:0]    quo_ff, quo_in;
   logic [SIZE_W-1:0]    rem_ff, rem_in;
   logic [SIZE_W-1:0]    div_ff, div_in;
   logic [SIZE_W-1:0]    rem_mid;

   // One restoring step: shift in a dividend bit and subtract if possible.
   function automatic logic [SIZE_W-1:0] rem_step(input logic [SIZE_W-1:0] r,
                                                  input logic              b,
                                                  input logic [SIZE_W-1:0] d);
      logic [SIZE_W:0] t;
      t = {r, b};
      if (t >= {1'b0, d}) begin
         t = t - {1'b0, d};
      end
      return t[SIZE_W-1:0];
   endfunction

   // Two steps per cycle, most significant dividend bits first.
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      rem_mid = rem_step(rem_ff, quo_ff[NAME_W-1], div_ff);
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIV_STEPS - 1);
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         rem_in = rem_step(rem_mid, quo_ff[NAME_W-2], div_ff);
         quo_in = quo_ff << 2;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            cnt_in = cnt_ff - DIV_CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   // The remainder is below the divisor, so it fits a slot index.
   assign busy      = busy_ff;
   assign remainder = rem_ff[SLOT_W-1:0];

endmodule

/* rtl/vtei_datapath.sv */
// ----------------------------------------------------------------------------
// Vertex table datapath
// Holds the slot memory, the table size register, the probe pointer, the
// per-edge results, the degree peak and the response register.
// ----------------------------------------------------------------------------
module vtei_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  vtei_pkg::req_type           req_data,
   input  vtei_pkg::cmd_type           cmd,
   output vtei_pkg::stat_type          stat,
   input  logic                        csr_valid,
   input  logic [vtei_pkg::SIZE_W-1:0] csr_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output vtei_pkg::rsp_type           rsp_data
);
   import vtei_pkg::*;

   typedef struct packed {
      logic              used;
      logic [NAME_W-1:0] name;
      logic [DEG_W-1:0]  degree;
   } word_type;

   word_type slot_mem [TABLE_DEPTH];
   word_type rd_word_ff;

   logic [SIZE_W-1:0] size_ff, size_in;
   logic [NAME_W-1:0] va_ff, va_in, vb_ff, vb_in;
   logic [SLOT_W-1:0] pos_ff, pos_in;
   logic [SIZE_W-1:0] cnt_ff, cnt_in;
   logic [SLOT_W-1:0] slot_a_ff, slot_a_in, slot_b_ff, slot_b_in;
   logic [DEG_W-1:0]  deg_a_ff, deg_a_in, deg_b_ff, deg_b_in;
   logic              ins_a_ff, ins_a_in;
   logic [DEG_W-1:0]  peak_ff, peak_in;
   logic [SLOT_W-1:0] clr_ff, clr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              busy_a, busy_b;
   logic [SLOT_W-1:0] home_a, home_b;
   logic [NAME_W-1:0] cur_name;
   logic              same_slot;
   logic [DEG_W-1:0]  deg_a_new, deg_b_new, peak_ab;

   logic              mem_we;
   logic [SLOT_W-1:0] mem_waddr;
   word_type          mem_wdata;

   function automatic logic [DEG_W-1:0] deg_inc(input logic [DEG_W-1:0] d);
      return (d == DEG_MAX) ? DEG_MAX : d + DEG_W'(1);
   endfunction

   // Home slots of both endpoints, computed side by side.
   vtei_div div_a (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.load_req),
      .dividend  (req_data.vertex_a),
      .divisor   (size_ff),
      .busy      (busy_a),
      .remainder (home_a)
   );

   vtei_div div_b (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.load_req),
      .dividend  (req_data.vertex_b),
      .divisor   (size_ff),
      .busy      (busy_b),
      .remainder (home_b)
   );

   // Probe comparison and the degree update of one edge.
   always_comb begin
      cur_name  = cmd.sel_b ? vb_ff : va_ff;
      same_slot = (slot_a_ff == slot_b_ff);
      if (same_slot) begin
         deg_a_new = deg_inc(deg_inc(deg_a_ff));
         deg_b_new = deg_a_new;
      end else begin
         deg_a_new = deg_inc(deg_a_ff);
         deg_b_new = deg_inc(deg_b_ff);
      end
      peak_ab = (deg_a_new > deg_b_new) ? deg_a_new : deg_b_new;
   end

   // Status toward the controller.
   always_comb begin
      stat.clear_last = (clr_ff == SLOT_W'(TABLE_DEPTH - 1));
      stat.div_done   = !busy_a && !busy_b;
      stat.hit        = !rd_word_ff.used || (rd_word_ff.name == cur_name);
      stat.probe_last = (cnt_ff == size_ff - SIZE_W'(1));
      stat.out_free   = !rsp_valid_ff || !rsp_stall;
   end

   // Table write port: clearing sweep, insertion, write-back or undo.
   always_comb begin
      mem_we           = 1'b0;
      mem_waddr        = pos_ff;
      mem_wdata.used   = 1'b1;
      mem_wdata.name   = cur_name;
      mem_wdata.degree = '0;
      if (cmd.clear_wr) begin
         mem_we    = 1'b1;
         mem_waddr = clr_ff;
         mem_wdata = '0;
      end else if (cmd.eval && !rd_word_ff.used) begin
         mem_we = 1'b1;
      end else if (cmd.write_a) begin
         mem_we           = 1'b1;
         mem_waddr        = slot_a_ff;
         mem_wdata.name   = va_ff;
         mem_wdata.degree = deg_a_ff;
      end else if (cmd.write_b) begin
         mem_we           = 1'b1;
         mem_waddr        = slot_b_ff;
         mem_wdata.name   = vb_ff;
         mem_wdata.degree = deg_b_ff;
      end else if (cmd.undo && ins_a_ff) begin
         mem_we         = 1'b1;
         mem_waddr      = slot_a_ff;
         mem_wdata.used = 1'b0;
         mem_wdata.name = va_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_waddr] <= mem_wdata;
      end
      rd_word_ff <= slot_mem[pos_ff];
   end

   // Next values of the datapath registers.
   always_comb begin
      size_in      = size_ff;
      va_in        = va_ff;
      vb_in        = vb_ff;
      pos_in       = pos_ff;
      cnt_in       = cnt_ff;
      slot_a_in    = slot_a_ff;
      slot_b_in    = slot_b_ff;
      deg_a_in     = deg_a_ff;
      deg_b_in     = deg_b_ff;
      ins_a_in     = ins_a_ff;
      peak_in      = peak_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      // Table size is held clamped to 1..TABLE_DEPTH.
      if (csr_valid) begin
         if (csr_data == '0) begin
            size_in = SIZE_W'(1);
         end else if (csr_data > SIZE_MAX) begin
            size_in = SIZE_MAX;
         end else begin
            size_in = csr_data;
         end
      end

      if (cmd.clear_wr) begin
         clr_in = clr_ff + SLOT_W'(1);
      end

      if (cmd.load_req) begin
         va_in    = req_data.vertex_a;
         vb_in    = req_data.vertex_b;
         ins_a_in = 1'b0;
      end

      if (cmd.start_a) begin
         pos_in = home_a;
         cnt_in = '0;
      end else if (cmd.start_b) begin
         pos_in = home_b;
         cnt_in = '0;
      end else if (cmd.probe_next) begin
         cnt_in = cnt_ff + SIZE_W'(1);
         if ({1'b0, pos_ff} == size_ff - SIZE_W'(1)) begin
            pos_in = '0;
         end else begin
            pos_in = pos_ff + SLOT_W'(1);
         end
      end

      // Record where the endpoint lives and its degree so far.
      if (cmd.eval && stat.hit) begin
         if (cmd.sel_b) begin
            slot_b_in = pos_ff;
            deg_b_in  = rd_word_ff.used ? rd_word_ff.degree : '0;
         end else begin
            slot_a_in = pos_ff;
            deg_a_in  = rd_word_ff.used ? rd_word_ff.degree : '0;
            ins_a_in  = !rd_word_ff.used;
         end
      end

      if (cmd.bump) begin
         deg_a_in = deg_a_new;
         deg_b_in = deg_b_new;
         if (peak_ab > peak_ff) begin
            peak_in = peak_ab;
         end
      end

      // Response register: a new result replaces one that was transferred.
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         if (cmd.out_fail) begin
            rsp_in.slot_a     = '0;
            rsp_in.slot_b     = '0;
            rsp_in.degree_a   = '0;
            rsp_in.degree_b   = '0;
            rsp_in.table_full = 1'b1;
         end else begin
            rsp_in.slot_a     = slot_a_ff;
            rsp_in.slot_b     = slot_b_ff;
            rsp_in.degree_a   = deg_a_ff;
            rsp_in.degree_b   = deg_b_ff;
            rsp_in.table_full = 1'b0;
         end
         rsp_in.max_degree = peak_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff      <= SIZE_MAX;
         peak_ff      <= '0;
         clr_ff       <= '0;
         ins_a_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         size_ff      <= size_in;
         peak_ff      <= peak_in;
         clr_ff       <= clr_in;
         ins_a_ff     <= ins_a_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      va_ff     <= va_in;
      vb_ff     <= vb_in;
      pos_ff    <= pos_in;
      cnt_ff    <= cnt_in;
      slot_a_ff <= slot_a_in;
      slot_b_ff <= slot_b_in;
      deg_a_ff  <= deg_a_in;
      deg_b_ff  <= deg_b_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* rtl/vtei_ctrl.sv */
// ----------------------------------------------------------------------------
// Vertex table controller
// Sequences the clearing sweep, the two probes of each edge, the degree
// write-back or the undo of a failed edge, and the response transfer.
// ----------------------------------------------------------------------------
module vtei_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  vtei_pkg::stat_type stat,
   output vtei_pkg::cmd_type  cmd
);
   import vtei_pkg::*;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV,
      ST_READ,
      ST_EVAL,
      ST_BUMP,
      ST_WRITE_A,
      ST_WRITE_B,
      ST_FAIL,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      sel_b_ff, sel_b_in;
   logic      fail_ff, fail_in;

   // Next state and the commands of the current cycle.
   always_comb begin
      state_in = state_ff;
      sel_b_in = sel_b_ff;
      fail_in  = fail_ff;
      cmd      = '0;
      cmd.sel_b    = sel_b_ff;
      cmd.out_fail = fail_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (stat.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_DIV;
            end
         end
         ST_DIV: begin
            if (stat.div_done) begin
               cmd.start_a = 1'b1;
               sel_b_in    = 1'b0;
               state_in    = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            if (stat.hit) begin
               if (sel_b_ff) begin
                  state_in = ST_BUMP;
               end else begin
                  cmd.start_b = 1'b1;
                  sel_b_in    = 1'b1;
                  state_in    = ST_READ;
               end
            end else if (stat.probe_last) begin
               state_in = ST_FAIL;
            end else begin
               cmd.probe_next = 1'b1;
               state_in       = ST_READ;
            end
         end
         ST_BUMP: begin
            cmd.bump = 1'b1;
            state_in = ST_WRITE_A;
         end
         ST_WRITE_A: begin
            cmd.write_a = 1'b1;
            state_in    = ST_WRITE_B;
         end
         ST_WRITE_B: begin
            cmd.write_b = 1'b1;
            fail_in     = 1'b0;
            state_in    = ST_FINISH;
         end
         ST_FAIL: begin
            cmd.undo = 1'b1;
            fail_in  = 1'b1;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         sel_b_ff <= 1'b0;
         fail_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         sel_b_ff <= sel_b_in;
         fail_ff  <= fail_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

/* rtl/vertex_table_edge_insert_top.sv */
// ----------------------------------------------------------------------------
// Vertex table edge insertion
// Open-addressed vertex table with linear probing: each edge finds or
// inserts both endpoint names and returns their slots and new degrees.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel (req_valid, req_stall, req_data) carries one edge
//   as two 32-bit vertex names; a transfer happens when req_valid is high
//   and req_stall is low. The response channel (rsp_valid, rsp_stall,
//   rsp_data) returns one result per edge in order. The csr channel writes
//   the table size; csr_ready is always high. The user must make writes
//   only while no edge is in flight; the block does not enforce this.
//   After reset a clearing sweep marks all 4096 slots free, one per cycle,
//   and req_stall stays high until the sweep is done.
//   One edge is handled at a time. Per edge, the remainder unit first finds
//   both home slots at two bits per cycle; each probe then does a registered
//   memory read and compare for every slot it visits; last come the degree
//   update and write-back of both entries, or the undo of a failed edge.
//   The result waits in an output register while rsp_stall is high; the
//   next edge is then already processed and only its result transfer waits.
// ----------------------------------------------------------------------------
module vertex_table_edge_insert_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  vtei_pkg::req_type           req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output vtei_pkg::rsp_type           rsp_data,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [vtei_pkg::SIZE_W-1:0] csr_data
);
   import vtei_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // The size register takes a write in any cycle.
   assign csr_ready = 1'b1;

   vtei_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   vtei_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .csr_valid (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

/* tb/sv/vertex_table_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Vertex table result checker
// Watches the request, response and csr channels of the vertex table. Each
// request transfer runs through a local copy of the linear-probing table to
// produce the expected result, and each response transfer is compared field
// by field with the oldest result still due.
// ----------------------------------------------------------------------------
module vertex_table_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_stall,
   input  vtei_pkg::req_type           req_data,
   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  vtei_pkg::rsp_type           rsp_data,
   input  logic                        csr_valid,
   input  logic                        csr_ready,
   input  logic [vtei_pkg::SIZE_W-1:0] csr_data,
   output int                          error_count,
   output int                          outstanding,
   output int                          results_seen,
   output int                          full_seen,
   output int                          peak_seen
);
   import vtei_pkg::*;

   // Local copy of the vertex table and its registers.
   bit                slot_taken [TABLE_DEPTH];
   logic [NAME_W-1:0] slot_label [TABLE_DEPTH];
   logic [DEG_W-1:0]  slot_deg   [TABLE_DEPTH];
   logic [DEG_W-1:0]  deg_peak;
   logic [SIZE_W-1:0] size_reg;

   rsp_type edge_results_due [$];
   rsp_type predicted;
   int      mismatches = 0;
   int      checked    = 0;
   int      full_count = 0;

   // Number of slots that probing covers under the current table size.
   function automatic int unsigned probe_span();
      if (size_reg == '0) return 1;
      if (size_reg > SIZE_MAX) return TABLE_DEPTH;
      return size_reg;
   endfunction

   // Look a name up from its home slot, taking the first free slot if absent.
   task automatic find_or_add(input logic [NAME_W-1:0] name, output bit found,
                              output int unsigned slot, output bit added);
      int unsigned span;
      int unsigned pos;
      int unsigned n;
      span  = probe_span();
      pos   = name % span;
      found = 1'b0;
      added = 1'b0;
      slot  = 0;
      for (n = 0; n < span && !found; n++) begin
         if (!slot_taken[pos]) begin
            slot_taken[pos] = 1'b1;
            slot_label[pos] = name;
            slot_deg[pos]   = '0;
            added = 1'b1;
            found = 1'b1;
            slot  = pos;
         end else if (slot_label[pos] == name) begin
            found = 1'b1;
            slot  = pos;
         end else begin
            pos = (pos + 1 >= span) ? 0 : pos + 1;
         end
      end
   endtask

   // Add one degree to a slot, saturating, and track the peak.
   task automatic bump_degree(input int unsigned slot);
      if (slot_deg[slot] < DEG_MAX) slot_deg[slot] = slot_deg[slot] + 1'b1;
      if (slot_deg[slot] > deg_peak) deg_peak = slot_deg[slot];
   endtask

   // Expected result of one edge; a full table leaves the contents untouched.
   task automatic predict_edge(input req_type edge_in, output rsp_type result);
      int unsigned slot_a;
      int unsigned slot_b;
      bit          ok;
      bit          added_a;
      bit          added_b;
      slot_b = 0;
      find_or_add(edge_in.vertex_a, ok, slot_a, added_a);
      if (ok) begin
         find_or_add(edge_in.vertex_b, ok, slot_b, added_b);
         // Release the slot just taken for the first endpoint.
         if (!ok && added_a) slot_taken[slot_a] = 1'b0;
      end
      result = '0;
      if (!ok) begin
         result.max_degree = deg_peak;
         result.table_full = 1'b1;
      end else begin
         bump_degree(slot_a);
         bump_degree(slot_b);
         result.slot_a     = slot_a[SLOT_W-1:0];
         result.slot_b     = slot_b[SLOT_W-1:0];
         result.degree_a   = slot_deg[slot_a];
         result.degree_b   = slot_deg[slot_b];
         result.max_degree = deg_peak;
      end
   endtask

   task automatic compare_field(input string label, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         mismatches++;
         $display("At %0t: %s mismatch, expected %0d, got %0d",
                  $time, label, want, got);
      end
   endtask

   // Compare one response transfer against the oldest result due.
   task automatic check_result(input rsp_type got);
      rsp_type want;
      checked++;
      if (edge_results_due.size() == 0) begin
         mismatches++;
         $display("At %0t: result with none due, expected nothing, got %h",
                  $time, got);
      end else begin
         want = edge_results_due.pop_front();
         if (want.table_full) full_count++;
         compare_field("slot_a", want.slot_a, got.slot_a);
         compare_field("slot_b", want.slot_b, got.slot_b);
         compare_field("degree_a", want.degree_a, got.degree_a);
         compare_field("degree_b", want.degree_b, got.degree_b);
         compare_field("max_degree", want.max_degree, got.max_degree);
         compare_field("table_full", want.table_full, got.table_full);
      end
   endtask

   // Follow every transfer on the three channels.
   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TABLE_DEPTH; i++) slot_taken[i] = 1'b0;
         deg_peak = '0;
         size_reg = SIZE_MAX;
         edge_results_due.delete();
      end else begin
         if (csr_valid && csr_ready) size_reg = csr_data;
         if (req_valid && !req_stall) begin
            predict_edge(req_data, predicted);
            edge_results_due.push_back(predicted);
         end
         if (rsp_valid && !rsp_stall) check_result(rsp_data);
      end
      error_count  <= mismatches;
      outstanding  <= edge_results_due.size();
      results_seen <= checked;
      full_seen    <= full_count;
      peak_seen    <= deg_peak;
   end

endmodule

/* tb/sv/tb_vertex_table_edge_insert_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Vertex table edge insertion testbench
// Drives edges into the vertex table under a series of table sizes, with
// bursty requests and a patterned response stall. A directed opening covers
// wraparound, size clamping and full tables; random phases mix repeated
// names, colliding names and fresh names; a short self-loop run at the end
// keeps raising one degree with the receiver never stalling. A checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_vertex_table_edge_insert_top;
   import vtei_pkg::*;

   localparam int QUIET_LIMIT      = 40000;
   localparam int RANDOM_EDGES     = 660;
   localparam int PHASES           = 11;
   localparam int SATURATION_LOOPS = 20;
   localparam int POOL_DEPTH       = 64;

   typedef enum int {STALL_NONE, STALL_COIN, STALL_SOLID, STALL_TOGGLE} stall_mode_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   req_type           req_data;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   rsp_type           rsp_data;
   logic              csr_valid;
   logic              csr_ready;
   logic [SIZE_W-1:0] csr_data;

   int error_count;
   int outstanding;
   int results_seen;
   int full_seen;
   int peak_seen;

   int                quiet_cycles  = 0;
   int                settings_used = 0;
   bit                stall_free    = 1'b0;
   int unsigned       cur_span;
   logic [NAME_W-1:0] name_pool [$];
   stall_mode_type    stall_mode    = STALL_NONE;
   int                stall_left    = 0;

   // Table sizes of the random phases; the last phase draws its own.
   logic [SIZE_W-1:0] phase_sizes [PHASES-1] =
      '{13'd16, 13'd1, 13'd3, 13'd257, 13'd4096, 13'd64, 13'd2, 13'd5000,
        13'd31, 13'h1FFF};

   vertex_table_edge_insert_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   vertex_table_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_data     (csr_data),
      .error_count  (error_count),
      .outstanding  (outstanding),
      .results_seen (results_seen),
      .full_seen    (full_seen),
      .peak_seen    (peak_seen)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Response stall: segments of random length, each with its own pattern.
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         stall_left = $urandom_range(5, 120);
      end
      stall_left--;
      if (stall_free || reset) begin
         rsp_stall <= 1'b0;
      end else begin
         case (stall_mode)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_COIN:  rsp_stall <= ($urandom_range(0, 1) == 1);
            STALL_SOLID: rsp_stall <= 1'b1;
            default:     rsp_stall <= ~rsp_stall;
         endcase
      end
   end

   // Watchdog: ends the run when no transfer happens for too long.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Watchdog: no transfer for %0d cycles, %0d results outstanding.",
                  QUIET_LIMIT, outstanding);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Offer one edge and hold it until the transfer; valid stays high after.
   task automatic send_edge(input logic [NAME_W-1:0] a, input logic [NAME_W-1:0] b);
      req_valid <= 1'b1;
      req_data  <= '{vertex_a: a, vertex_b: b};
      do @(posedge clock); while (req_stall !== 1'b0);
      name_pool.push_back(a);
      name_pool.push_back(b);
      while (name_pool.size() > POOL_DEPTH) void'(name_pool.pop_front());
   endtask

   task automatic pause_sender(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Stop sending until every result due has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_table_size(input logic [SIZE_W-1:0] value);
      drain_results();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      cur_span = (value == '0) ? 1 : ((value > SIZE_MAX) ? TABLE_DEPTH : value);
      settings_used++;
   endtask

   // Mostly names already in the table or colliding with them, some fresh.
   function automatic logic [NAME_W-1:0] pick_name();
      int unsigned       roll;
      logic [NAME_W-1:0] base;
      roll = $urandom_range(0, 99);
      if (name_pool.size() > 0 && roll < 55) begin
         base = name_pool[$urandom_range(0, name_pool.size() - 1)];
         if (roll < 35) return base;
         return base + cur_span * $urandom_range(1, 8);
      end
      if (roll < 65) return $urandom_range(0, cur_span - 1);
      if (roll < 70) return 32'hFFFF_FFFF - $urandom_range(0, 15);
      return $urandom();
   endfunction

   task automatic random_phase(input int edges);
      int                sent;
      int                burst;
      int                k;
      logic [NAME_W-1:0] a;
      logic [NAME_W-1:0] b;
      sent = 0;
      while (sent < edges) begin
         burst = $urandom_range(1, 12);
         for (k = 0; k < burst && sent < edges; k++) begin
            a = pick_name();
            b = ($urandom_range(0, 9) == 0) ? a : pick_name();
            send_edge(a, b);
            sent++;
         end
         if ($urandom_range(0, 29) == 0) drain_results();
         else if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 25));
      end
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_data  = '0;
      cur_span  = TABLE_DEPTH;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      settings_used = 1;

      // Default size: self-loop, wraparound past the last slot, extremes.
      send_edge(32'h0000_0000, 32'h0000_0000);
      send_edge(32'hFFFF_FFFF, 32'd4095);
      send_edge(32'd4096, 32'h0000_0000);
      send_edge(32'h8000_0000, 32'h7FFF_FFFF);
      send_edge(32'hAAAA_AAAA, 32'h5555_5555);

      // Size zero acts as one slot: hits and full tables on either side.
      set_table_size(13'd0);
      send_edge(32'h0000_0000, 32'h0000_0000);
      send_edge(32'h0000_0000, 32'd12345);
      send_edge(32'd777, 32'h0000_0000);

      // Nearly full small table: the first endpoint's insertion is undone.
      set_table_size(13'd6);
      send_edge(32'd1000001, 32'd1000002);
      send_edge(32'd1000001, 32'h0000_0000);
      send_edge(32'd2000000, 32'd1000001);

      // Size above the table depth is clamped.
      set_table_size(13'h1FFF);
      send_edge(32'd4095, 32'd4095);
      send_edge(32'hFFFF_FFFF, 32'h0000_0000);
      send_edge(32'd4097, 32'd8193);

      set_table_size(13'd1);
      send_edge(32'h0000_0000, 32'h0000_0000);
      send_edge(32'd5, 32'd5);

      set_table_size(13'd4096);
      send_edge(32'd1, 32'd4097);
      send_edge(32'd4097, 32'd1);

      // Random phases, each under its own table size.
      foreach (phase_sizes[i]) begin
         set_table_size(phase_sizes[i]);
         random_phase(RANDOM_EDGES / PHASES);
      end
      set_table_size($urandom_range(1, 8191));
      random_phase(RANDOM_EDGES / PHASES);

      // Closing self-loop run on vertex zero, back to back with no stall.
      set_table_size(13'd4096);
      stall_free <= 1'b1;
      repeat (SATURATION_LOOPS) send_edge(32'h0000_0000, 32'h0000_0000);
      send_edge(32'h0000_0000, 32'h1234_5678);
      send_edge(32'hFFFF_FFFF, 32'h0000_0000);
      stall_free <= 1'b0;

      drain_results();
      repeat (40) @(posedge clock);

      $display("Checked %0d edge results, %0d of them on a full table, over %0d table sizes.",
               results_seen, full_seen, settings_used);
      $display("Peak degree reported was %0d at the end of the closing self-loop run.",
               peak_seen);
      if (outstanding != 0) $display("%0d expected results never arrived.", outstanding);
      if (error_count == 0 && outstanding == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/vtei_pkg.sv
rtl/vtei_div.sv
rtl/vtei_datapath.sv
rtl/vtei_ctrl.sv
rtl/vertex_table_edge_insert_top.sv
tb/sv/vertex_table_checker.sv
tb/sv/tb_vertex_table_edge_insert_top.sv
